// ----- rtl/core/vtv_pkg.sv -----
// ----------------------------------------------------------------------------
// vtv_pkg
// Shared types and constants of the vertex transform and viewport unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vtv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OP_W          = 34;
  localparam int unsigned PIX_W         = 16;
  localparam int unsigned SIZE_W        = 13;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd128;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd64;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;
  localparam logic SEL_MODELVIEW  = 1'b0;
  localparam logic SEL_PROJECTION = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CACC,
    ST_CWR,
    ST_VMUL,
    ST_VACC,
    ST_VWR,
    ST_CHK,
    ST_DSTART,
    ST_DWAIT,
    ST_PXMUL,
    ST_PXWR,
    ST_PYMUL,
    ST_PYWR,
    ST_DONE
  } vtv_state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/vtv_if.sv -----
// ----------------------------------------------------------------------------
// vtv_in_if / vtv_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface vtv_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               matrix_select;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic signed [31:0] vw;

  modport source (output valid, kind, matrix_select, element_index, element_value,
                  vx, vy, vz, vw, input ready);
  modport sink (input valid, kind, matrix_select, element_index, element_value,
                vx, vy, vz, vw, output ready);
endinterface

interface vtv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic signed [31:0] ndc_z;
  logic               inside_xy;
  logic               inside_z;
  logic               w_zero;

  modport source (output valid, pixel_x, pixel_y, ndc_z, inside_xy, inside_z, w_zero,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, ndc_z, inside_xy, inside_z, w_zero,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/vtv_mac.sv -----
// ----------------------------------------------------------------------------
// vtv_mac
// Shared multiplier with floor-shift accumulator and pixel scaling outputs.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_mac
  import vtv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mac_ctrl_t                ctrl_i,
  input  wire logic signed [OP_W-1:0]   a_i,
  input  wire logic signed [OP_W-1:0]   b_i,
  output logic signed [DATA_W-1:0]      dot_o,
  output logic signed [PIX_W-1:0]       pix_o
);

  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned ACC_W  = 2 * DATA_W + 2 - FRAC_BITS;
  localparam int unsigned SH     = FRAC_BITS + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [PROD_W-1:0] pix_full;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_sh = prod_q >>> FRAC_BITS;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + prod_sh[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (acc_q[ACC_W-1:DATA_W-1] == '0 || acc_q[ACC_W-1:DATA_W-1] == '1) begin
      dot_o = acc_q[DATA_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      dot_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      dot_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign prod_bias = prod_q[PROD_W-1] ?
                     prod_q + {{(PROD_W-SH){1'b0}}, {SH{1'b1}}} : prod_q;
  assign pix_full  = prod_bias >>> SH;

  always_comb begin
    if (pix_full[PROD_W-1:PIX_W-1] == '0 || pix_full[PROD_W-1:PIX_W-1] == '1) begin
      pix_o = pix_full[PIX_W-1:0];
    end else if (pix_full[PROD_W-1]) begin
      pix_o = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      pix_o = {1'b0, {(PIX_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/vtv_div.sv -----
// ----------------------------------------------------------------------------
// vtv_div
// Bit-serial restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_div
  import vtv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [DATA_W-1:0] num_i,
  input  wire logic signed [DATA_W-1:0] den_i,
  output logic                          done_o,
  output logic signed [DATA_W-1:0]      quo_o
);

  localparam int unsigned NUM_W = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  sh_q, sh_n;
  logic [DATA_W-1:0] rem_q, rem_n, dm_q;
  logic [DATA_W:0]   rem_sh;
  logic              ge;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, done_q;
  logic [DATA_W-1:0] num_mag, den_mag;
  logic signed [DATA_W-1:0] quo_q, quo_d;

  assign num_mag = num_i[DATA_W-1] ? DATA_W'(-num_i) : num_i;
  assign den_mag = den_i[DATA_W-1] ? DATA_W'(-den_i) : den_i;

  assign rem_sh = {rem_q, sh_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dm_q};
  assign rem_n  = ge ? DATA_W'(rem_sh - {1'b0, dm_q}) : rem_sh[DATA_W-1:0];
  assign sh_n   = {sh_q[NUM_W-2:0], ge};

  always_comb begin
    if (neg_q) begin
      if (sh_n[NUM_W-1:DATA_W] != '0 || (sh_n[DATA_W-1] && sh_n[DATA_W-2:0] != '0)) begin
        quo_d = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        quo_d = DATA_W'(-sh_n[DATA_W-1:0]);
      end
    end else begin
      if (sh_n[NUM_W-1:DATA_W-1] != '0) begin
        quo_d = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        quo_d = sh_n[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dm_q  <= den_mag;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (cnt_q != '0) begin
      sh_q  <= sh_n;
      rem_q <= rem_n;
      if (cnt_q == CNT_W'(1)) begin
        quo_q <= quo_d;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/vertex_transform_viewport_unit.sv -----
// Steps per vertex, from accept to result: the combined matrix, the vertex product,
//   the w check, three serial divides, pixel scaling and the output register; the
//   divides and pixel scaling are skipped when the transformed w is zero.
// Vertices are taken one at a time, only while idle; a waiting result holds back the
//   next vertex. One matrix write per cycle while idle.
// The work runs on one shared multiplier and a one-bit-per-cycle divider.
// Reset: modelview and projection matrices zero, frame 128 x 64, no result pending.
// ----------------------------------------------------------------------------
// vertex_transform_viewport_unit
// Modelview/projection transform, perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_viewport_unit
  import vtv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  vtv_in_if.sink                    req_i,
  vtv_out_if.source                 rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i
);

  localparam logic signed [DATA_W-1:0] ONE_D =
    {{(DATA_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [OP_W-1:0] ONE_OP =
    {{(OP_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  vtv_state_e state_q, state_d;

  logic signed [DATA_W-1:0] mv_q [16];
  logic signed [DATA_W-1:0] pj_q [16];
  logic signed [DATA_W-1:0] cm_q [16];
  logic signed [DATA_W-1:0] vert_q [4];
  logic signed [DATA_W-1:0] clip_q [4];
  logic signed [DATA_W-1:0] nx_q, ny_q, nz_q;
  logic [SIZE_W-1:0]        fw_q, fh_q, fw_fac, fh_fac;
  logic [3:0]               ent_q, ent_d;
  logic [1:0]               k_q, k_d;

  logic signed [PIX_W-1:0]  px_q, py_q;
  logic signed [DATA_W-1:0] rz_q;
  logic                     rin_xy_q, rin_z_q, rwz_q;

  logic                     out_vld_q, out_vld_d, out_load;
  logic signed [PIX_W-1:0]  out_px_q, out_py_q;
  logic signed [DATA_W-1:0] out_z_q;
  logic                     out_ixy_q, out_iz_q, out_wz_q;

  mac_ctrl_t                mac_ctrl;
  logic signed [OP_W-1:0]   mac_a, mac_b;
  logic signed [DATA_W-1:0] dot;
  logic signed [PIX_W-1:0]  pix;
  logic                     div_start, div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic                     accept;

  vtv_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i, .rst_ni, .ctrl_i(mac_ctrl), .a_i(mac_a), .b_i(mac_b),
    .dot_o(dot), .pix_o(pix)
  );

  vtv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(clip_q[k_q]), .den_i(clip_q[3]),
    .done_o(div_done), .quo_o(div_quo)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign fw_fac      = (fw_q == '0) ? '0 : fw_q - 1'b1;
  assign fh_fac      = (fh_q == '0) ? '0 : fh_q - 1'b1;

  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    k_d       = k_q;
    mac_ctrl  = '0;
    mac_a     = OP_W'(pj_q[{k_q, ent_q[1:0]}]);
    mac_b     = OP_W'(mv_q[{ent_q[3:2], k_q}]);
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.kind == KIND_VERTEX) begin
          mac_ctrl.acc_clr = 1'b1;
          ent_d   = '0;
          k_d     = '0;
          state_d = ST_CMUL;
        end
      end
      ST_CMUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d = ST_CACC;
      end
      ST_CACC: begin
        mac_ctrl.acc_en = 1'b1;
        k_d     = k_q + 1'b1;
        state_d = (k_q == 2'd3) ? ST_CWR : ST_CMUL;
      end
      ST_CWR: begin
        mac_ctrl.acc_clr = 1'b1;
        ent_d   = ent_q + 1'b1;
        state_d = (ent_q == 4'd15) ? ST_VMUL : ST_CMUL;
      end
      ST_VMUL: begin
        mac_a = OP_W'(cm_q[{k_q, ent_q[1:0]}]);
        mac_b = OP_W'(vert_q[k_q]);
        mac_ctrl.mul_en = 1'b1;
        state_d = ST_VACC;
      end
      ST_VACC: begin
        mac_ctrl.acc_en = 1'b1;
        k_d     = k_q + 1'b1;
        state_d = (k_q == 2'd3) ? ST_VWR : ST_VMUL;
      end
      ST_VWR: begin
        mac_ctrl.acc_clr = 1'b1;
        ent_d   = ent_q + 1'b1;
        state_d = (ent_q[1:0] == 2'd3) ? ST_CHK : ST_VMUL;
      end
      ST_CHK: begin
        k_d     = '0;
        state_d = (clip_q[3] == '0) ? ST_DONE : ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          k_d     = k_q + 1'b1;
          state_d = (k_q == 2'd2) ? ST_PXMUL : ST_DSTART;
        end
      end
      ST_PXMUL: begin
        mac_a = OP_W'(nx_q) + ONE_OP;
        mac_b = OP_W'(fw_fac);
        mac_ctrl.mul_en = 1'b1;
        state_d = ST_PXWR;
      end
      ST_PXWR: begin
        state_d = ST_PYMUL;
      end
      ST_PYMUL: begin
        mac_a = ONE_OP - OP_W'(ny_q);
        mac_b = OP_W'(fh_fac);
        mac_ctrl.mul_en = 1'b1;
        state_d = ST_PYWR;
      end
      ST_PYWR: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !rsp_o.ready;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ent_q     <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
      fw_q      <= FRAME_WIDTH_RST;
      fh_q      <= FRAME_HEIGHT_RST;
      for (int i = 0; i < 16; i++) begin
        mv_q[i] <= '0;
        pj_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ent_q     <= ent_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && req_i.kind == KIND_WRITE) begin
        if (req_i.matrix_select == SEL_PROJECTION) begin
          pj_q[req_i.element_index] <= req_i.element_value;
        end else begin
          mv_q[req_i.element_index] <= req_i.element_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.kind == KIND_VERTEX) begin
      vert_q[0] <= req_i.vx;
      vert_q[1] <= req_i.vy;
      vert_q[2] <= req_i.vz;
      vert_q[3] <= req_i.vw;
    end
    if (state_q == ST_CWR) begin
      cm_q[ent_q] <= dot;
    end
    if (state_q == ST_VWR) begin
      clip_q[ent_q[1:0]] <= dot;
    end
    if (state_q == ST_CHK) begin
      px_q     <= '0;
      py_q     <= '0;
      rz_q     <= '0;
      rin_xy_q <= 1'b0;
      rin_z_q  <= 1'b0;
      rwz_q    <= (clip_q[3] == '0);
    end
    if (state_q == ST_DWAIT && div_done) begin
      case (k_q)
        2'd0:    nx_q <= div_quo;
        2'd1:    ny_q <= div_quo;
        default: nz_q <= div_quo;
      endcase
    end
    if (state_q == ST_PXWR) begin
      px_q     <= pix;
      rz_q     <= nz_q;
      rin_xy_q <= nx_q >= -ONE_D && nx_q <= ONE_D && ny_q >= -ONE_D && ny_q <= ONE_D;
      rin_z_q  <= nz_q >= -ONE_D && nz_q <= ONE_D;
    end
    if (state_q == ST_PYWR) begin
      py_q <= pix;
    end
    if (out_load) begin
      out_px_q  <= px_q;
      out_py_q  <= py_q;
      out_z_q   <= rz_q;
      out_ixy_q <= rin_xy_q;
      out_iz_q  <= rin_z_q;
      out_wz_q  <= rwz_q;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.pixel_x   = out_px_q;
  assign rsp_o.pixel_y   = out_py_q;
  assign rsp_o.ndc_z     = out_z_q;
  assign rsp_o.inside_xy = out_ixy_q;
  assign rsp_o.inside_z  = out_iz_q;
  assign rsp_o.w_zero    = out_wz_q;

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DWAIT)
    else $error("divider finished outside its wait state");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == KIND_WRITE) |=> state_q == ST_IDLE && !$rose(out_vld_q))
    else $error("matrix write started work or a result");

  a_wzero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_wz_q) |-> out_px_q == '0 && out_py_q == '0 && out_z_q == '0
      && !out_ixy_q && !out_iz_q)
    else $error("zero-w result carries nonzero fields");
`endif

endmodule
`default_nettype wire
